// ===== hdl/hrbp_pkg.sv =====
// shared types, constants and helpers for the http response byte parser
package hrbp_pkg;

    localparam int HRBP_HEADER_STORE = 512;
    localparam int HRBP_PREFIX_LEN   = 4;
    localparam int HRBP_MIN_HEADER   = 12;
    localparam int HRBP_BODY_W       = 24;
    localparam int HRBP_CODE_W       = 16;

    localparam logic [7:0] HRBP_CH_CR    = 8'h0D;
    localparam logic [7:0] HRBP_CH_LF    = 8'h0A;
    localparam logic [7:0] HRBP_CH_H     = 8'h48;
    localparam logic [7:0] HRBP_CH_T     = 8'h54;
    localparam logic [7:0] HRBP_CH_P     = 8'h50;
    localparam logic [7:0] HRBP_CH_SPACE = 8'h20;

    // ascii zero removed from all three digits: 48 * 111
    localparam logic [HRBP_CODE_W-1:0] HRBP_CODE_BIAS = 16'd5328;
    localparam logic [HRBP_CODE_W-1:0] HRBP_WEIGHT_HUNDREDS = 16'd100;
    localparam logic [HRBP_CODE_W-1:0] HRBP_WEIGHT_TENS     = 16'd10;

    localparam logic [HRBP_BODY_W-1:0] HRBP_BODY_LIMIT_RESET = '1;

    typedef enum logic [1:0] {
        TERM_IDLE,
        TERM_CR,
        TERM_CRLF,
        TERM_CRLFCR
    } hrbp_term_t;

    typedef struct packed {
        logic                   ended_before;
        logic                   ended;
        logic                   found;
        logic [HRBP_CODE_W-1:0] code;
    } hrbp_hdr_t;

    typedef struct packed {
        logic                   valid;
        logic [HRBP_BODY_W-1:0] index;
        logic                   overflow;
    } hrbp_body_t;

    function automatic logic [7:0] hrbp_prefix_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = HRBP_CH_H;
            2'd1:    ch = HRBP_CH_T;
            2'd2:    ch = HRBP_CH_T;
            default: ch = HRBP_CH_P;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/hrbp_header.sv =====
// header tracking: terminator detection, byte count, prefix and status code
module hrbp_header #(
    parameter int HEADER_STORE = hrbp_pkg::HRBP_HEADER_STORE
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              new_response,
    input  logic [7:0]        data_byte,
    output hrbp_pkg::hrbp_hdr_t status
);
    import hrbp_pkg::*;

    localparam int CountW = $clog2(HEADER_STORE + 1);
    localparam logic [CountW-1:0] StoreCnt  = CountW'(HEADER_STORE);
    localparam logic [CountW-1:0] PrefixCnt = CountW'(HRBP_PREFIX_LEN);
    localparam logic [CountW-1:0] MinCnt    = CountW'(HRBP_MIN_HEADER);

    hrbp_term_t             term_reg, term_base, term_next;
    logic                   ended_reg, ended_base, ended_next;
    logic [CountW-1:0]      count_reg, count_base, count_next;
    logic                   prefix_reg, prefix_base, prefix_next;
    logic                   space_reg, space_base, space_next;
    logic [1:0]             digits_reg, digits_base, digits_next;
    logic [7:0]             digit_reg [3];
    logic [7:0]             digit_base [3];
    logic [7:0]             digit_next [3];
    logic [HRBP_CODE_W-1:0] code_reg, code_base, code_next;
    logic                   found_reg, found_base, found_next;

    // new response clears parse state before the byte is handled
    always_comb begin
        term_base   = new_response ? TERM_IDLE : term_reg;
        ended_base  = new_response ? 1'b0 : ended_reg;
        count_base  = new_response ? '0 : count_reg;
        prefix_base = new_response ? 1'b1 : prefix_reg;
        space_base  = new_response ? 1'b0 : space_reg;
        digits_base = new_response ? 2'd0 : digits_reg;
        code_base   = new_response ? '0 : code_reg;
        found_base  = new_response ? 1'b0 : found_reg;
        for (int i = 0; i < 3; i++) begin
            digit_base[i] = new_response ? 8'd0 : digit_reg[i];
        end
    end

    always_comb begin
        term_next   = term_base;
        ended_next  = ended_base;
        count_next  = count_base;
        prefix_next = prefix_base;
        space_next  = space_base;
        digits_next = digits_base;
        code_next   = code_base;
        found_next  = found_base;
        for (int i = 0; i < 3; i++) begin
            digit_next[i] = digit_base[i];
        end
        if (!ended_base) begin
            if (count_base < StoreCnt) begin
                if (count_base < PrefixCnt && data_byte != hrbp_prefix_char(count_base[1:0])) begin
                    prefix_next = 1'b0;
                end
                if (!space_base) begin
                    if (data_byte == HRBP_CH_SPACE) begin
                        space_next = 1'b1;
                    end
                end else if (digits_base != 2'd3) begin
                    case (digits_base)
                        2'd0:    digit_next[0] = data_byte;
                        2'd1:    digit_next[1] = data_byte;
                        2'd2:    digit_next[2] = data_byte;
                        default: ;
                    endcase
                    digits_next = digits_base + 2'd1;
                end
                count_next = count_base + CountW'(1);
            end

            unique case (term_base)
                TERM_IDLE:   term_next = (data_byte == HRBP_CH_CR) ? TERM_CR : TERM_IDLE;
                TERM_CR: begin
                    if (data_byte == HRBP_CH_LF) begin
                        term_next = TERM_CRLF;
                    end else begin
                        term_next = (data_byte == HRBP_CH_CR) ? TERM_CR : TERM_IDLE;
                    end
                end
                TERM_CRLF:   term_next = (data_byte == HRBP_CH_CR) ? TERM_CRLFCR : TERM_IDLE;
                TERM_CRLFCR: begin
                    if (data_byte == HRBP_CH_LF) begin
                        term_next  = TERM_IDLE;
                        ended_next = 1'b1;
                    end else begin
                        term_next = (data_byte == HRBP_CH_CR) ? TERM_CR : TERM_IDLE;
                    end
                end
                default:     term_next = TERM_IDLE;
            endcase

            if (ended_next && count_next > MinCnt && prefix_next && digits_next == 2'd3) begin
                code_next  = ({8'd0, digit_next[0]} * HRBP_WEIGHT_HUNDREDS)
                           + ({8'd0, digit_next[1]} * HRBP_WEIGHT_TENS)
                           + {8'd0, digit_next[2]} - HRBP_CODE_BIAS;
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg   <= TERM_IDLE;
            ended_reg  <= 1'b0;
            count_reg  <= '0;
            prefix_reg <= 1'b1;
            space_reg  <= 1'b0;
            digits_reg <= 2'd0;
            code_reg   <= '0;
            found_reg  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                digit_reg[i] <= 8'd0;
            end
        end else if (step) begin
            term_reg   <= term_next;
            ended_reg  <= ended_next;
            count_reg  <= count_next;
            prefix_reg <= prefix_next;
            space_reg  <= space_next;
            digits_reg <= digits_next;
            code_reg   <= code_next;
            found_reg  <= found_next;
            for (int i = 0; i < 3; i++) begin
                digit_reg[i] <= digit_next[i];
            end
        end
    end

    assign status.ended_before = ended_base;
    assign status.ended        = ended_next;
    assign status.found        = found_next;
    assign status.code         = code_next;

endmodule

// ===== hdl/hrbp_body.sv =====
// body byte counting against the limit with sticky overflow
module hrbp_body (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic                                new_response,
    input  logic                                header_ended,
    input  logic [hrbp_pkg::HRBP_BODY_W-1:0]    body_limit,
    output hrbp_pkg::hrbp_body_t                result
);
    import hrbp_pkg::*;

    logic [HRBP_BODY_W-1:0] count_reg, count_base, count_next;
    logic                   ovf_reg, ovf_base, ovf_next;
    logic                   valid;

    always_comb begin
        count_base = new_response ? '0 : count_reg;
        ovf_base   = new_response ? 1'b0 : ovf_reg;
        count_next = count_base;
        ovf_next   = ovf_base;
        valid      = 1'b0;
        if (header_ended && !ovf_base) begin
            if (count_base >= body_limit) begin
                ovf_next = 1'b1;
            end else begin
                valid      = 1'b1;
                count_next = count_base + HRBP_BODY_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (step) begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign result.valid    = valid;
    assign result.index    = valid ? count_base : '0;
    assign result.overflow = ovf_next;

endmodule

// ===== hdl/http_response_byte_parser_unit.sv =====
// top level of the http response byte parser with input and result registers
// an input transfer is held in the input register, and its result then moves to the result register on the master side
// throughput: one byte per cycle while the master side accepts, set by the single-pass update between the registers
// a stalled master side holds the result register, and the input register then fills
// reset: synchronous active-low aresetn clears parse state and sets body_limit to all ones
module http_response_byte_parser_unit #(
    parameter int HEADER_STORE = hrbp_pkg::HRBP_HEADER_STORE
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [hrbp_pkg::HRBP_BODY_W-1:0] cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic [0:0]                       s_tuser,   // new_response
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // body_byte, body_index, header_complete, status_found, status_code, overflow, pad
    output logic [55:0]                      m_tdata,
    output logic [0:0]                       m_tuser    // body_valid
);
    import hrbp_pkg::*;

    logic [HRBP_BODY_W-1:0] body_limit_reg;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_new_reg;
    logic                   out_valid_reg;
    logic [55:0]            out_data_reg;
    logic                   out_body_valid_reg;
    logic                   out_free;
    logic                   step;
    hrbp_hdr_t              hdr;
    hrbp_body_t             body;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_limit_reg <= HRBP_BODY_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            body_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_new_reg  <= s_tuser[0];
        end
    end

    hrbp_header #(
        .HEADER_STORE(HEADER_STORE)
    ) u_header (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .new_response(in_new_reg),
        .data_byte   (in_byte_reg),
        .status      (hdr)
    );

    hrbp_body u_body (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .new_response(in_new_reg),
        .header_ended(hdr.ended_before),
        .body_limit  (body_limit_reg),
        .result      (body)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_body_valid_reg <= body.valid;
            out_data_reg <= {5'd0, body.overflow, hdr.code, hdr.found, hdr.ended,
                             body.index, (body.valid ? in_byte_reg : 8'd0)};
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_body_valid_reg;

endmodule

// ===== tb/tb_http_response_byte_parser_unit.sv =====
// self-checking testbench for the http response byte parser unit
`timescale 1ns / 1ps

module tb_http_response_byte_parser_unit;
    import hrbp_pkg::*;

    localparam int CH_ZERO    = 48;
    localparam int PHASE_LEN  = 60;
    localparam int MAX_CYCLES = 1000000;

    typedef struct {
        logic                   body_valid;
        logic [7:0]             body_byte;
        logic [HRBP_BODY_W-1:0] body_index;
        logic                   header_complete;
        logic                   status_found;
        logic [HRBP_CODE_W-1:0] status_code;
        logic                   overflow;
    } parse_result_t;

    class hrbp_scoreboard;
        logic [HRBP_BODY_W-1:0] body_limit;
        hrbp_term_t             term;
        logic                   hdr_done;
        int                     hdr_count;
        logic                   prefix_good;
        logic                   space_hit;
        int                     n_digits;
        logic [7:0]             digits[3];
        logic [HRBP_CODE_W-1:0] code;
        logic                   found;
        logic [HRBP_BODY_W-1:0] body_cnt;
        logic                   ovf;
        logic [7:0]             prefix_chars[4];
        parse_result_t          expected_q[$];
        int                     mismatches;

        function new();
            prefix_chars = '{HRBP_CH_H, HRBP_CH_T, HRBP_CH_T, HRBP_CH_P};
            body_limit   = HRBP_BODY_LIMIT_RESET;
            mismatches   = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            term        = TERM_IDLE;
            hdr_done    = 1'b0;
            hdr_count   = 0;
            prefix_good = 1'b1;
            space_hit   = 1'b0;
            n_digits    = 0;
            digits      = '{8'h00, 8'h00, 8'h00};
            code        = '0;
            found       = 1'b0;
            body_cnt    = '0;
            ovf         = 1'b0;
        endfunction

        function void header_byte(logic [7:0] c);
            int v;
            if (hdr_count < HRBP_HEADER_STORE) begin
                if (hdr_count < HRBP_PREFIX_LEN && c != prefix_chars[hdr_count])
                    prefix_good = 1'b0;
                if (!space_hit) begin
                    if (c == HRBP_CH_SPACE)
                        space_hit = 1'b1;
                end else if (n_digits < 3) begin
                    digits[n_digits] = c;
                    n_digits++;
                end
                hdr_count++;
            end
            if (term == TERM_IDLE && c == HRBP_CH_CR) begin
                term = TERM_CR;
            end else if (term == TERM_CR && c == HRBP_CH_LF) begin
                term = TERM_CRLF;
            end else if (term == TERM_CRLF && c == HRBP_CH_CR) begin
                term = TERM_CRLFCR;
            end else if (term == TERM_CRLFCR && c == HRBP_CH_LF) begin
                hdr_done = 1'b1;
                term     = TERM_IDLE;
            end else if (c == HRBP_CH_CR) begin
                term = TERM_CR;
            end else begin
                term = TERM_IDLE;
            end
            if (hdr_done && hdr_count > HRBP_MIN_HEADER && prefix_good && n_digits == 3) begin
                v = (int'(digits[0]) - CH_ZERO) * 100 + (int'(digits[1]) - CH_ZERO) * 10
                    + (int'(digits[2]) - CH_ZERO);
                code  = v[HRBP_CODE_W-1:0];
                found = 1'b1;
            end
        endfunction

        function void note_input(logic [7:0] c, logic new_resp);
            parse_result_t r;
            r.body_valid = 1'b0;
            r.body_byte  = '0;
            r.body_index = '0;
            if (new_resp)
                clear_parse();
            if (!hdr_done) begin
                header_byte(c);
            end else if (!ovf) begin
                if (body_cnt >= body_limit) begin
                    ovf = 1'b1;
                end else begin
                    r.body_valid = 1'b1;
                    r.body_byte  = c;
                    r.body_index = body_cnt;
                    body_cnt     = body_cnt + 1'b1;
                end
            end
            r.header_complete = hdr_done;
            r.status_found    = found;
            r.status_code     = code;
            r.overflow        = ovf;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [55:0] d, logic [0:0] u);
            parse_result_t e;
            parse_result_t g;
            g.body_valid      = u[0];
            g.body_byte       = d[7:0];
            g.body_index      = d[31:8];
            g.header_complete = d[32];
            g.status_found    = d[33];
            g.status_code     = d[49:34];
            g.overflow        = d[50];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t", $realtime);
                return;
            end
            e = expected_q.pop_front();
            if (g.body_valid !== e.body_valid || g.body_byte !== e.body_byte
                    || g.body_index !== e.body_index
                    || g.header_complete !== e.header_complete
                    || g.status_found !== e.status_found
                    || g.status_code !== e.status_code || g.overflow !== e.overflow) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: exp v=%0b b=%02h i=%0d h=%0b f=%0b c=%0d o=%0b",
                             $realtime, e.body_valid, e.body_byte, e.body_index,
                             e.header_complete, e.status_found, $signed(e.status_code),
                             e.overflow);
                    $display("                 got v=%0b b=%02h i=%0d h=%0b f=%0b c=%0d o=%0b",
                             g.body_valid, g.body_byte, g.body_index, g.header_complete,
                             g.status_found, $signed(g.status_code), g.overflow);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [HRBP_BODY_W-1:0] cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [55:0]            m_tdata;
    logic [0:0]             m_tuser;

    hrbp_scoreboard sb;
    logic [7:0]     tx_bytes[$];
    int             phase_items;
    int             cycles = 0;
    int             stall_left;
    bit             quiet;

    http_response_byte_parser_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] filler_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return HRBP_CH_CR;
        else if (r < 16)
            return HRBP_CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("tb_http_response_byte_parser_unit NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    task automatic send_byte(logic [7:0] c, logic new_resp);
        int gap;
        gap = quiet ? 0 : pick_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= new_resp;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(c, new_resp);
        phase_items++;
    endtask

    task automatic send_frame();
        foreach (tx_bytes[i])
            send_byte(tx_bytes[i], i == 0);
        tx_bytes.delete();
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endtask

    task automatic push_crlf();
        tx_bytes.push_back(HRBP_CH_CR);
        tx_bytes.push_back(HRBP_CH_LF);
    endtask

    task automatic push_body(int n);
        repeat (n)
            tx_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_body_limit(logic [HRBP_BODY_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.body_limit = v;
    endtask

    task automatic build_response(bit odd_digits, bit bad_prefix, bit long_hdr);
        int lines;
        push_str("HTTP/1.1 ");
        repeat (3) begin
            if (odd_digits)
                tx_bytes.push_back(8'($urandom_range(0, 255)));
            else
                tx_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        tx_bytes.push_back(HRBP_CH_SPACE);
        repeat ($urandom_range(0, 6))
            tx_bytes.push_back(8'($urandom_range(65, 90)));
        push_crlf();
        if (long_hdr) begin
            repeat ($urandom_range(HRBP_HEADER_STORE, HRBP_HEADER_STORE + 40))
                tx_bytes.push_back(8'($urandom_range(32, 126)));
            push_crlf();
        end
        lines = $urandom_range(0, 3);
        repeat (lines) begin
            repeat ($urandom_range(1, 12))
                tx_bytes.push_back(filler_byte());
            push_crlf();
        end
        push_crlf();
        if (bad_prefix)
            tx_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        push_body(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 40));
    endtask

    task automatic build_late_space();
        push_str("HTTP");
        repeat (HRBP_HEADER_STORE)
            tx_bytes.push_back(8'($urandom_range(65, 90)));
        push_str(" 200");
        push_crlf();
        push_crlf();
        push_body($urandom_range(1, 10));
    endtask

    task automatic build_short();
        if ($urandom_range(0, 1))
            push_str("HTTP");
        else
            tx_bytes.push_back(filler_byte());
        if ($urandom_range(0, 3) != 0)
            tx_bytes.push_back(HRBP_CH_SPACE);
        repeat ($urandom_range(0, 4))
            tx_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0)
            tx_bytes.push_back(HRBP_CH_CR);
        push_crlf();
        push_crlf();
        push_body($urandom_range(0, 8));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(5, 30))
            send_byte(filler_byte(), $urandom_range(0, 19) == 0);
    endtask

    task automatic random_phase(bit with_long);
        int r;
        phase_items = 0;
        if (with_long) begin
            build_response(1'b0, 1'b0, 1'b1);
            send_frame();
            build_late_space();
            send_frame();
        end
        while (phase_items < PHASE_LEN) begin
            quiet = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                build_response(1'b0, 1'b0, 1'b0);
                send_frame();
            end else if (r < 70) begin
                build_response(1'b0, 1'b1, 1'b0);
                send_frame();
            end else if (r < 80) begin
                build_response(1'b1, 1'b0, 1'b0);
                send_frame();
            end else if (r < 88) begin
                build_short();
                send_frame();
            end else begin
                send_noise();
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        sb          = new();
        quiet       = 1'b0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // non-digit status bytes, stray cr before the blank line, two body bytes
        push_str("HTTP/1 ");
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'h2F);
        tx_bytes.push_back(HRBP_CH_CR);
        push_crlf();
        push_crlf();
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        send_frame();
        // exactly twelve header bytes, so no code is formed
        push_str("HTTP 200");
        push_crlf();
        push_crlf();
        tx_bytes.push_back(8'h41);
        send_frame();

        random_phase(1'b0);
        set_body_limit('0);
        random_phase(1'b0);
        set_body_limit(24'd1);
        random_phase(1'b1);
        set_body_limit(24'd3);
        random_phase(1'b0);
        set_body_limit(24'($urandom_range(0, 40)));
        random_phase(1'b0);
        set_body_limit(HRBP_BODY_LIMIT_RESET);
        random_phase(1'b0);
        set_body_limit(24'($urandom_range(0, 24'hFFFFFF)));
        random_phase(1'b0);
        set_body_limit(24'($urandom_range(0, 40)));
        random_phase(1'b0);

        drain();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("tb_http_response_byte_parser_unit OK");
        else
            $display("tb_http_response_byte_parser_unit NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hrbp_pkg.sv
hdl/hrbp_header.sv
hdl/hrbp_body.sv
hdl/http_response_byte_parser_unit.sv
tb/tb_http_response_byte_parser_unit.sv
